>>> hdl/sgr_pkg.sv
`timescale 1ns / 1ps

package sgr_pkg;

   localparam int GROUP_MAX = 16;
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 5;
   localparam int CNT_W     = $clog2(GROUP_MAX + 1);
   localparam int IDX_W     = $clog2(GROUP_MAX);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REV,
      ST_ALIGN,
      ST_FWD
   } state_type;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } shift_ctrl_type;

   // zero acts as one, anything above the cell count saturates
   function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] gs);
      logic [CNT_W-1:0] k;
      if (gs == '0) begin
         k = CNT_W'(1);
      end else if (int'(gs) > GROUP_MAX) begin
         k = CNT_W'(GROUP_MAX);
      end else begin
         k = CNT_W'(gs);
      end
      return k;
   endfunction

endpackage

>>> hdl/sgr_cell.sv
`timescale 1ns / 1ps

module sgr_cell (
   input  logic                          clock,
   input  sgr_pkg::shift_ctrl_type       ctrl,
   input  logic [sgr_pkg::DATA_W-1:0]    left_in,
   input  logic [sgr_pkg::DATA_W-1:0]    right_in,
   output logic [sgr_pkg::DATA_W-1:0]    value_out
);
   import sgr_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      priority if (ctrl.shift_up) begin
         value_in = left_in;
      end else if (ctrl.shift_down) begin
         value_in = right_in;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

>>> hdl/sgr_chain.sv
`timescale 1ns / 1ps

module sgr_chain (
   input  logic                          clock,
   input  sgr_pkg::shift_ctrl_type       ctrl,
   input  logic [sgr_pkg::DATA_W-1:0]    push_value,
   output logic [sgr_pkg::DATA_W-1:0]    head_value,
   output logic [sgr_pkg::DATA_W-1:0]    tail_value
);
   import sgr_pkg::*;

   logic [DATA_W-1:0] cell_value [GROUP_MAX];

   // cell 0 holds the newest item; shift up pushes, shift down pops the head
   for (genvar i = 0; i < GROUP_MAX; i++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = push_value;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end

      if (i == GROUP_MAX - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end

      sgr_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_in   (left_v),
         .right_in  (right_v),
         .value_out (cell_value[i])
      );
   end

   assign head_value = cell_value[0];
   assign tail_value = cell_value[GROUP_MAX-1];

endmodule

>>> hdl/stream_group_reverser.sv
`timescale 1ns / 1ps

// Reverses a stream of signed 32-bit items in groups of csr_wr_data items
// (1 to 16; 0 acts as 1, larger values saturate at 16). Items are held in a
// row of 16 shift cells, newest in the first cell. An item that does not
// finish a group is just taken. An item that completes a group of n is
// taken and the group then drains newest first, one item per cycle while
// the output register is free. An item carrying tlast on an incomplete
// group of n first shifts the row 16 - n times to bring the oldest item
// to the last cell, then drains n items in arrival order. The shift row
// is the only path, so no new item is taken while a group drains; the
// output register lets a new item in while the final result still waits.
// rsp_tlast marks the last result caused by one input item, rsp_tuser
// marks the final result of a list.

module stream_group_reverser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sgr_pkg::CFG_W-1:0]     csr_wr_data,   // group_size
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sgr_pkg::DATA_W-1:0]    req_tdata,     // value
   input  logic                          req_tlast,     // list_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sgr_pkg::DATA_W-1:0]    rsp_tdata,     // out_value
   output logic                          rsp_tlast,     // run_last
   output logic                          rsp_tuser      // stream_last
);
   import sgr_pkg::*;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              end_ff, end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_user_ff, rsp_user_in;

   shift_ctrl_type    ctrl;
   logic [DATA_W-1:0] head_value;
   logic [DATA_W-1:0] tail_value;
   logic              accept;
   logic              out_free;
   logic [CNT_W-1:0]  n_new;
   logic [CNT_W-1:0]  k_eff;

   sgr_chain u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .push_value (req_tdata),
      .head_value (head_value),
      .tail_value (tail_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign n_new      = fill_ff + CNT_W'(1);
   assign k_eff      = eff_size(size_ff);

   always_comb begin
      state_in        = state_ff;
      size_in         = csr_wr_en ? csr_wr_data : size_ff;
      fill_in         = fill_ff;
      remain_in       = remain_ff;
      pos_in          = pos_ff;
      end_in          = end_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_user_in     = rsp_user_ff;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.shift_up = 1'b1;
               end_in        = req_tlast;
               remain_in     = n_new;
               if (n_new >= k_eff) begin
                  fill_in  = '0;
                  state_in = ST_REV;
               end else if (req_tlast) begin
                  fill_in  = '0;
                  pos_in   = IDX_W'(fill_ff);
                  state_in = (IDX_W'(fill_ff) == IDX_W'(GROUP_MAX - 1)) ? ST_FWD : ST_ALIGN;
               end else begin
                  fill_in = n_new;
               end
            end
         end
         ST_REV: begin
            if (out_free) begin
               ctrl.shift_down = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = head_value;
               rsp_last_in     = (remain_ff == CNT_W'(1));
               rsp_user_in     = (remain_ff == CNT_W'(1)) && end_ff;
               remain_in       = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ALIGN: begin
            // walk the oldest item out to the last cell
            ctrl.shift_up = 1'b1;
            pos_in        = pos_ff + IDX_W'(1);
            if (pos_ff == IDX_W'(GROUP_MAX - 2)) begin
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            if (out_free) begin
               ctrl.shift_up = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = tail_value;
               rsp_last_in   = (remain_ff == CNT_W'(1));
               rsp_user_in   = (remain_ff == CNT_W'(1));
               remain_in     = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CFG_W'(1);
         fill_ff      <= '0;
         remain_ff    <= '0;
         pos_ff       <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         pos_ff       <= pos_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   a_list_end_on_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("list end flagged on a result that does not close its run");

   a_fill_below_max: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) < GROUP_MAX)
      else $error("buffer fill reached the cell count without draining");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV || state_ff == ST_FWD || state_ff == ST_ALIGN) |-> remain_ff != '0)
      else $error("drain running with nothing left to send");

   a_list_end_drains: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> state_ff != ST_IDLE)
      else $error("list end item did not start a drain");
`endif

endmodule

>>> test/tb_stream_group_reverser.sv
`timescale 1ns / 1ps

module tb_stream_group_reverser;

   import sgr_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              run_last;
      logic              stream_last;
   } out_item_type;

   typedef struct packed {
      logic              do_cfg;
      logic [CFG_W-1:0]  gs;
      logic [DATA_W-1:0] val;
      logic              list_end;
      logic              typed;
      out_item_type      want;
   } dir_row_type;

   localparam int N_DIR      = 23;
   localparam int SETTLE_CYC = 40;
   localparam int HOLD_CYC   = 400;
   localparam int RAND_ITEMS = 47;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [CFG_W-1:0]  csr_wr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;    // value
   logic              req_tlast;    // list_end
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;    // out_value
   logic              rsp_tlast;    // run_last
   logic              rsp_tuser;    // stream_last

   // reversal model state
   logic [CFG_W-1:0]  grp_size;
   int unsigned       grp_fill;
   logic [DATA_W-1:0] grp_buf [GROUP_MAX];

   out_item_type      fresh_out [$];
   out_item_type      pending_out [$];
   dir_row_type       dir_tab [N_DIR];

   int                errors;
   int                burst_left;
   bit                hold_req;

   stream_group_reverser u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // collect one value, emit a full group newest first or a cut-short list in order
   function automatic void predict_group(input logic [DATA_W-1:0] v, input logic end_in);
      int unsigned  k;
      int unsigned  n;
      out_item_type r;
      if (grp_size == '0) begin
         k = 1;
      end else if (int'(grp_size) > GROUP_MAX) begin
         k = GROUP_MAX;
      end else begin
         k = int'(grp_size);
      end
      if (grp_fill >= GROUP_MAX) begin
         grp_fill = 0;
      end
      grp_buf[IDX_W'(grp_fill)] = v;
      grp_fill++;
      n = grp_fill;
      if (n >= k) begin
         for (int i = 0; i < n; i++) begin
            r.val         = grp_buf[IDX_W'(n - 1 - i)];
            r.run_last    = (i + 1 == n);
            r.stream_last = (i + 1 == n) && end_in;
            fresh_out.push_back(r);
         end
         grp_fill = 0;
      end else if (end_in) begin
         for (int i = 0; i < n; i++) begin
            r.val         = grp_buf[IDX_W'(i)];
            r.run_last    = (i + 1 == n);
            r.stream_last = (i + 1 == n);
            fresh_out.push_back(r);
         end
         grp_fill = 0;
      end
   endfunction

   task automatic send_item(input logic [DATA_W-1:0] v, input logic end_in,
                            input logic typed, input out_item_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= end_in;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_group(v, end_in);
      if (typed) begin
         pending_out.push_back(want);
      end else begin
         foreach (fresh_out[i]) pending_out.push_back(fresh_out[i]);
      end
      fresh_out.delete();
   endtask

   // only while idle: all results in, then let any quiet item settle
   task automatic write_group_size(input logic [CFG_W-1:0] gs);
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= gs;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      grp_size   = gs;
      burst_left = 0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h0000_0000;
         3:       v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // result checker
   initial begin
      out_item_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_out.size() == 0) begin
               note_mismatch("unexpected item", rsp_tdata, '0);
            end else begin
               w = pending_out.pop_front();
               if (rsp_tdata !== w.val) note_mismatch("out_value", rsp_tdata, w.val);
               if (rsp_tlast !== w.run_last) begin
                  note_mismatch("run_last", DATA_W'(rsp_tlast), DATA_W'(w.run_last));
               end
               if (rsp_tuser !== w.stream_last) begin
                  note_mismatch("stream_last", DATA_W'(rsp_tuser), DATA_W'(w.stream_last));
               end
            end
         end
      end
   end

   // receiver back-pressure
   initial begin
      int mode;
      int mode_left;
      int stall_left;
      int tick;
      mode       = 0;
      mode_left  = 0;
      stall_left = 0;
      tick       = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYC) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 4 == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                     if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
                  end
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int          sent;
      int          nlists;
      int          len;
      int unsigned k;
      logic [CFG_W-1:0] gs;
      logic        end_in;

      errors      = 0;
      burst_left  = 0;
      hold_req    = 1'b0;
      grp_size    = CFG_W'(1);
      grp_fill    = 0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;

      // pass through after reset, zero size, reversal, saturation, shrink mid group
      dir_tab[0]  = '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}};
      dir_tab[1]  = '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}};
      dir_tab[2]  = '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}};
      dir_tab[3]  = '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}};
      dir_tab[4]  = '{1'b1, 5'd0,  32'h1234_5678, 1'b0, 1'b1, '{32'h1234_5678, 1'b1, 1'b0}};
      dir_tab[5]  = '{1'b1, 5'd4,  32'h0000_0001, 1'b0, 1'b0, '0};
      dir_tab[6]  = '{1'b0, 5'd0,  32'h0000_0002, 1'b0, 1'b0, '0};
      dir_tab[7]  = '{1'b0, 5'd0,  32'h0000_0003, 1'b0, 1'b0, '0};
      dir_tab[8]  = '{1'b0, 5'd0,  32'h0000_0004, 1'b0, 1'b0, '0};
      dir_tab[9]  = '{1'b0, 5'd0,  32'h0000_0005, 1'b0, 1'b0, '0};
      dir_tab[10] = '{1'b0, 5'd0,  32'h0000_0006, 1'b1, 1'b0, '0};
      dir_tab[11] = '{1'b1, 5'd3,  32'hAAAA_AAAA, 1'b0, 1'b0, '0};
      dir_tab[12] = '{1'b0, 5'd0,  32'h5555_5555, 1'b0, 1'b0, '0};
      dir_tab[13] = '{1'b0, 5'd0,  32'hDEAD_BEEF, 1'b1, 1'b0, '0};
      dir_tab[14] = '{1'b1, 5'd8,  32'h0000_0010, 1'b0, 1'b0, '0};
      dir_tab[15] = '{1'b0, 5'd0,  32'h0000_0020, 1'b0, 1'b0, '0};
      dir_tab[16] = '{1'b0, 5'd0,  32'h0000_0030, 1'b0, 1'b0, '0};
      dir_tab[17] = '{1'b1, 5'd2,  32'h0000_0040, 1'b0, 1'b0, '0};
      dir_tab[18] = '{1'b1, 5'd31, 32'hC000_0000, 1'b0, 1'b0, '0};
      dir_tab[19] = '{1'b0, 5'd0,  32'h3FFF_FFFF, 1'b0, 1'b0, '0};
      dir_tab[20] = '{1'b0, 5'd0,  32'h0F0F_0F0F, 1'b0, 1'b0, '0};
      dir_tab[21] = '{1'b0, 5'd0,  32'hF0F0_F0F0, 1'b0, 1'b0, '0};
      dir_tab[22] = '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_DIR; r++) begin
         if (dir_tab[r].do_cfg) write_group_size(dir_tab[r].gs);
         send_item(dir_tab[r].val, dir_tab[r].list_end, dir_tab[r].typed, dir_tab[r].want);
      end

      // long receiver hold-off while the sender keeps pushing
      write_group_size(CFG_W'(4));
      hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_item(pick_value(), (i % 11 == 10), 1'b0, '0);
      end

      sent = 0;
      while (sent < RAND_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       gs = CFG_W'(1);
            1:       gs = CFG_W'(16);
            2:       gs = CFG_W'(0);
            3:       gs = CFG_W'(31);
            4:       gs = CFG_W'(17);
            default: gs = CFG_W'($urandom_range(2, 8));
         endcase
         write_group_size(gs);
         if (gs == '0) begin
            k = 1;
         end else if (int'(gs) > GROUP_MAX) begin
            k = GROUP_MAX;
         end else begin
            k = int'(gs);
         end
         nlists = $urandom_range(1, 3);
         for (int l = 0; l < nlists; l++) begin
            if (sent >= RAND_ITEMS) break;
            len = $urandom_range(1, 2 * k + 3);
            if (len > RAND_ITEMS - sent) len = RAND_ITEMS - sent;
            for (int i = 0; i < len; i++) begin
               end_in = (i == len - 1);
               // leave a list open now and then so the next size meets a partial group
               if (end_in && l == nlists - 1 && $urandom_range(0, 4) == 0) end_in = 1'b0;
               send_item(pick_value(), end_in, 1'b0, '0);
            end
            sent += len;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sgr_pkg.sv
hdl/sgr_cell.sv
hdl/sgr_chain.sv
hdl/stream_group_reverser.sv
test/tb_stream_group_reverser.sv
